/* rtl/fpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants for the four-plane tile compositor.
// ----------------------------------------------------------------------------
package fpc_pkg;

  localparam int unsigned NUM_PLANES  = 4;
  localparam int unsigned PLANE_AW    = 12;
  localparam int unsigned PLANE_BYTES = 1 << PLANE_AW;
  localparam int unsigned MAP_AW      = 10;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PW    = $clog2(QUEUE_DEPTH);

  // plane numbers
  localparam logic [1:0] PLANE_B = 2'd0;
  localparam logic [1:0] PLANE_D = 2'd1;
  localparam logic [1:0] PLANE_E = 2'd2;
  localparam logic [1:0] PLANE_F = 2'd3;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // register indexes
  localparam logic [2:0] REG_SCROLL_D     = 3'd0;
  localparam logic [2:0] REG_SCROLL_E     = 3'd1;
  localparam logic [2:0] REG_SCROLL_F     = 3'd2;
  localparam logic [2:0] REG_PALETTE_BANK = 3'd3;
  localparam logic [2:0] REG_VERT_OFFSET  = 3'd4;
  localparam logic [2:0] REG_HORIZ_OFFSET = 3'd5;

  typedef struct packed {
    logic [7:0] scroll_d;
    logic [7:0] scroll_e;
    logic [7:0] scroll_f;
    logic [1:0] palette_bank;
    logic [7:0] vert_offset;
    logic [7:0] horiz_offset;
  } fpc_cfg_t;

  // one queued item, classified by the front
  typedef struct packed {
    logic                             is_write;
    logic [1:0]                       plane;
    logic [PLANE_AW-1:0]              address;
    logic [7:0]                       write_data;
    logic [NUM_PLANES-1:0][MAP_AW-1:0] map_addr;
    logic [NUM_PLANES-1:0][2:0]       row_lo;
    logic [2:0]                       x_lo;
    logic [7:0]                       screen_x;
    logic [7:0]                       screen_y;
    logic                             visible;
  } fpc_item_t;

  typedef struct packed {
    logic                full;
    logic                empty;
    logic [QUEUE_PW:0]   count;
  } fpc_qstat_t;

endpackage : fpc_pkg
`default_nettype wire

/* rtl/fpc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_front
// Accepts items, classifies writes and pixels, computes map addresses and
// screen position.
// ----------------------------------------------------------------------------
module fpc_front
  import fpc_pkg::*;
(
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [1:0]  in_plane,
  input  wire logic [11:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [7:0]  in_pixel_x,
  input  wire logic [7:0]  in_pixel_y,
  input  wire fpc_cfg_t    cfg,
  input  wire fpc_qstat_t  q_stat,
  output logic             q_push,
  output fpc_item_t        q_item
);

  logic [NUM_PLANES-1:0][7:0] scroll;
  logic [NUM_PLANES-1:0][7:0] row;
  logic [9:0]                 sx;
  logic [9:0]                 sy;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    scroll[PLANE_B] = 8'd0;
    scroll[PLANE_D] = cfg.scroll_d;
    scroll[PLANE_E] = cfg.scroll_e;
    scroll[PLANE_F] = cfg.scroll_f;
    for (int p = 0; p < NUM_PLANES; p++) begin
      row[p] = in_pixel_y - scroll[p];
    end
  end

  assign sy = {2'b00, in_pixel_y} + {{2{cfg.vert_offset[7]}}, cfg.vert_offset};
  assign sx = {2'b00, in_pixel_x} - {{2{cfg.horiz_offset[7]}}, cfg.horiz_offset};

  always_comb begin
    q_item            = '0;
    q_item.is_write   = (in_op == OP_WRITE);
    q_item.plane      = in_plane;
    q_item.address    = in_address;
    q_item.write_data = in_write_data;
    for (int p = 0; p < NUM_PLANES; p++) begin
      q_item.map_addr[p] = {row[p][7:3], in_pixel_x[7:3]};
      q_item.row_lo[p]   = row[p][2:0];
    end
    q_item.x_lo     = in_pixel_x[2:0];
    q_item.screen_x = sx[7:0];
    q_item.screen_y = sy[7:0];
    q_item.visible  = (sx[9:8] == 2'b00) && (sy[9:8] == 2'b00);
  end

endmodule : fpc_front
`default_nettype wire

/* rtl/fpc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_queue
// Small FIFO between front and back.
// ----------------------------------------------------------------------------
module fpc_queue
  import fpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire fpc_item_t push_item,
  input  wire logic      pop,
  output fpc_item_t      head_item,
  output fpc_qstat_t     stat
);

  fpc_item_t             entry_r [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_PW:0]     count_r, count_nxt;
  logic                  do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign stat.full  = (count_r == (QUEUE_PW+1)'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;
  assign head_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule : fpc_queue
`default_nettype wire

/* rtl/fpc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_back
// Video RAM planes and the map / pattern read pipeline with output register.
// ----------------------------------------------------------------------------
module fpc_back
  import fpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire fpc_item_t  q_item,
  output logic            q_pop,
  input  wire logic [1:0] palette_bank,
  output logic            s2_valid,
  output logic            adv,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [9:0]      out_pen,
  output logic [7:0]      out_screen_x,
  output logic [7:0]      out_screen_y,
  output logic            out_visible
);

  logic                       take;
  logic [NUM_PLANES-1:0][7:0] map_q;
  logic [NUM_PLANES-1:0][7:0] gfx_q;

  logic                       s1_valid_r;
  logic [NUM_PLANES-1:0][2:0] s1_row_r;
  logic [2:0]                 s1_xlo_r;
  logic [7:0]                 s1_sx_r, s1_sy_r;
  logic                       s1_vis_r;

  logic                       s2_valid_r;
  logic [3:0]                 s2_color_r;
  logic [2:0]                 s2_xlo_r;
  logic [7:0]                 s2_sx_r, s2_sy_r;
  logic                       s2_vis_r;

  logic                       out_valid_r;
  logic [9:0]                 out_pen_r;
  logic [7:0]                 out_sx_r, out_sy_r;
  logic                       out_vis_r;

  logic [NUM_PLANES-1:0]      pbit;

  assign adv      = !out_valid_r || !out_stall;
  assign take     = adv && q_valid;
  assign q_pop    = take;
  assign s2_valid = s2_valid_r;

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    logic [7:0] mem [PLANE_BYTES];

    always_ff @(posedge clk) begin
      if (take) begin
        if (q_item.is_write && (q_item.plane == 2'(p))) begin
          mem[q_item.address] <= q_item.write_data;
        end
        if (!q_item.is_write) begin
          map_q[p] <= mem[{2'b00, q_item.map_addr[p]}];
        end
      end
      if (adv) begin
        gfx_q[p] <= mem[{1'b1, map_q[p], s1_row_r[p]}];
      end
    end

    assign pbit[p] = gfx_q[p][~s2_xlo_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_valid && !q_item.is_write;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_row_r   <= q_item.row_lo;
      s1_xlo_r   <= q_item.x_lo;
      s1_sx_r    <= q_item.screen_x;
      s1_sy_r    <= q_item.screen_y;
      s1_vis_r   <= q_item.visible;

      s2_color_r <= map_q[PLANE_B][7:4];
      s2_xlo_r   <= s1_xlo_r;
      s2_sx_r    <= s1_sx_r;
      s2_sy_r    <= s1_sy_r;
      s2_vis_r   <= s1_vis_r;

      out_pen_r  <= {palette_bank, pbit[PLANE_D], pbit[PLANE_E], pbit[PLANE_F],
                     pbit[PLANE_B], s2_color_r};
      out_sx_r   <= s2_sx_r;
      out_sy_r   <= s2_sy_r;
      out_vis_r  <= s2_vis_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pen      = out_pen_r;
  assign out_screen_x = out_sx_r;
  assign out_screen_y = out_sy_r;
  assign out_visible  = out_vis_r;

endmodule : fpc_back
`default_nettype wire

/* rtl/four_plane_tile_compositor_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_plane_tile_compositor_unit
// Four-plane tile compositor: video RAM writes and per-pixel composition.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  op, plane, address, write_data,
//                                            pixel_x, pixel_y
//   out      output     out_valid/out_stall  pen, screen_x, screen_y, visible
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// One item per cycle sustained while out does not stall. A pixel result is
// valid on out after its input transfer writes the queue and the map read,
// pattern read and output register have each taken it in turn.
// A 4-entry queue lets the input side keep taking items while out stalls, until it is full.
// Reset clears valid flags, queue pointers and config registers; video RAM
// and data registers are not cleared.
// ----------------------------------------------------------------------------
module four_plane_tile_compositor_unit
  import fpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [1:0]  in_plane,
  input  wire logic [11:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [7:0]  in_pixel_x,
  input  wire logic [7:0]  in_pixel_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_pen,
  output logic [7:0]       out_screen_x,
  output logic [7:0]       out_screen_y,
  output logic             out_visible,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  fpc_cfg_t   cfg_r;
  fpc_item_t  push_item;
  fpc_item_t  head_item;
  fpc_qstat_t q_stat;
  logic       q_push;
  logic       q_pop;
  logic       s2_valid;
  logic       adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCROLL_D:     cfg_r.scroll_d     <= cfg_wdata;
        REG_SCROLL_E:     cfg_r.scroll_e     <= cfg_wdata;
        REG_SCROLL_F:     cfg_r.scroll_f     <= cfg_wdata;
        REG_PALETTE_BANK: cfg_r.palette_bank <= cfg_wdata[1:0];
        REG_VERT_OFFSET:  cfg_r.vert_offset  <= cfg_wdata;
        REG_HORIZ_OFFSET: cfg_r.horiz_offset <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fpc_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_plane      (in_plane),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .cfg           (cfg_r),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  fpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  fpc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (!q_stat.empty),
    .q_item       (head_item),
    .q_pop        (q_pop),
    .palette_bank (cfg_r.palette_bank),
    .s2_valid     (s2_valid),
    .adv          (adv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pen      (out_pen),
    .out_screen_x (out_screen_x),
    .out_screen_y (out_screen_y),
    .out_visible  (out_visible)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue count lost a transfer");

  a_pipe_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && adv) |=> out_valid)
    else $error("pixel dropped before output register");

endmodule : four_plane_tile_compositor_unit
`default_nettype wire
